// ----- sv/swrc_pkg.sv -----
// ----------------------------------------------------------------------------
// Sliding window replay check package
// Types and constants shared by the replay window core and its top level.
// ----------------------------------------------------------------------------
package swrc_pkg;

  localparam int unsigned CounterWidth = 63;
  localparam int unsigned MarkWidth    = 64;
  localparam int unsigned CountWidth   = 32;
  localparam int unsigned WordBits     = 64;

  localparam logic [CountWidth-1:0] CountMax = '1;

  typedef enum logic {
    CMD_CHECK  = 1'b0,
    CMD_COMMIT = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                    command;
    logic [CounterWidth-1:0] counter;
  } in_item_t;

  typedef struct packed {
    logic                  accepted;
    logic [CountWidth-1:0] replay_total;
    logic [MarkWidth-1:0]  next_expected;
  } out_item_t;

endpackage

// ----- sv/swrc_core.sv -----
// ----------------------------------------------------------------------------
// Replay window core
// Holds the high-water mark, the seen bitmap and the replay count, and works
// out one check or commit per enabled cycle.
// ----------------------------------------------------------------------------
module swrc_core #(
  parameter int unsigned WINDOW_BITS  = 1024,
  parameter int unsigned WINDOW_WORDS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  swrc_pkg::in_item_t  item_i,
  output swrc_pkg::out_item_t result_o
);

  localparam int unsigned StoreBits = swrc_pkg::WordBits * WINDOW_WORDS;
  localparam int unsigned OffWidth  = $clog2(StoreBits);
  localparam int unsigned ShWidth   = $clog2(WINDOW_BITS);
  localparam int unsigned MW        = swrc_pkg::MarkWidth;

  localparam logic [MW-1:0] WindowLen = MW'(WINDOW_BITS);
  localparam logic [MW-1:0] StoreLen  = MW'(StoreBits);

  logic [MW-1:0]                   hw_q, hw_d;
  logic [StoreBits-1:0]            bitmap_q, bitmap_d;
  logic [swrc_pkg::CountWidth-1:0] cnt_q, cnt_d;

  logic [MW-1:0]        counter;
  logic [MW-1:0]        diff;
  logic [MW-1:0]        off_full;
  logic [MW-1:0]        shift;
  logic [OffWidth-1:0]  off_idx;
  logic [ShWidth-1:0]   sh_amt;
  logic                 behind;
  logic                 in_range;
  logic                 stored;
  logic                 seen;
  logic                 is_commit;
  logic                 reject;
  logic [StoreBits-1:0] aged;

  always_comb begin
    counter   = {1'b0, item_i.counter};
    is_commit = (item_i.command == swrc_pkg::CMD_COMMIT);
    behind    = counter < hw_q;
    // Distance below the mark; offset is one less than this.
    diff      = hw_q - counter;
    off_full  = diff - MW'(1);
    off_idx   = off_full[OffWidth-1:0];
    in_range  = diff <= WindowLen;
    stored    = diff <= StoreLen;
    seen      = behind && in_range && stored && bitmap_q[off_idx];
    reject    = !is_commit && behind && (!in_range || seen);

    // Advance of the mark on a commit at or ahead of it.
    shift  = counter + MW'(1) - hw_q;
    sh_amt = shift[ShWidth-1:0];
    if (shift >= WindowLen) begin
      aged = '0;
    end else begin
      aged = bitmap_q << sh_amt;
    end

    hw_d     = hw_q;
    bitmap_d = bitmap_q;
    if (is_commit) begin
      if (!behind) begin
        hw_d     = counter + MW'(1);
        // The committed counter sits right below the new mark.
        bitmap_d = aged | StoreBits'(1);
      end else if (in_range && stored) begin
        bitmap_d = bitmap_q | (StoreBits'(1) << off_idx);
      end
    end

    cnt_d = cnt_q;
    if (reject && (cnt_q != swrc_pkg::CountMax)) begin
      cnt_d = cnt_q + swrc_pkg::CountWidth'(1);
    end

    result_o.accepted      = !reject;
    result_o.replay_total  = cnt_d;
    result_o.next_expected = hw_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q     <= '0;
      bitmap_q <= '0;
      cnt_q    <= '0;
    end else if (step_i) begin
      hw_q     <= hw_d;
      bitmap_q <= bitmap_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ----- sv/sliding_window_replay_check_top.sv -----
// ----------------------------------------------------------------------------
// Sliding window replay check
// Anti-replay window over packet nonce counters with check and commit items.
// ----------------------------------------------------------------------------
// Each input transfer is captured in an input register, evaluated against the
// window state combinationally, and its result is held in an output register,
// so the block takes one item per cycle while the output side is not stalled,
// and a result is presented from the output register once its item has moved
// on from the input register. The rate is set by the update of the high-water
// mark, the seen bitmap and the replay count, which each item reads and writes
// before the next one.
module sliding_window_replay_check_top #(
  parameter int unsigned WINDOW_BITS  = 1024,
  parameter int unsigned WINDOW_WORDS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  swrc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output swrc_pkg::out_item_t out_data_o
);

  logic                in_valid_q, in_valid_d;
  swrc_pkg::in_item_t  in_item_q;
  logic                out_valid_q, out_valid_d;
  swrc_pkg::out_item_t out_item_q;
  swrc_pkg::out_item_t result;
  logic                fire;
  logic                in_xfer;

  // The held item moves on when the output register is free or being emptied.
  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;
  assign in_xfer    = in_valid_i && in_ready_o;

  swrc_core #(
    .WINDOW_BITS  (WINDOW_BITS),
    .WINDOW_WORDS (WINDOW_WORDS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (fire),
    .item_i   (in_item_q),
    .result_o (result)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_item_q <= in_data_i;
    end
    if (fire) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

endmodule

// ----- tb/sv/sliding_window_replay_check_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sliding window replay check testbench
// Sends check and commit items through the replay window and compares every
// result with a cycle-free model of the window kept in the testbench. It
// covers the window edges, bitmap aging and clearing, commits far behind,
// high counter values, back-pressure that fills the block, and random traffic
// around the moving high-water mark.
// ----------------------------------------------------------------------------
module sliding_window_replay_check_top_tb;

  localparam int unsigned WIN_BITS     = 1024;
  localparam int unsigned WIN_WORDS    = 16;
  localparam int unsigned MAX_IDLE     = 18;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;

  localparam logic [swrc_pkg::MarkWidth-1:0] COUNTER_TOP =
    {1'b0, {swrc_pkg::CounterWidth{1'b1}}};

  logic                clk_i = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  swrc_pkg::in_item_t  in_data = '0;
  logic                out_ready = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  swrc_pkg::out_item_t out_data_o;

  // Window model state, updated once per accepted input transfer.
  logic [swrc_pkg::MarkWidth-1:0]  mark_q = '0;
  logic [WIN_BITS-1:0]             seen_q = '0;
  logic [swrc_pkg::CountWidth-1:0] rejects_q = '0;

  swrc_pkg::out_item_t verdict_q[$];

  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int replays_seen = 0;
  int quiet_cycles = 0;

  sliding_window_replay_check_top #(
    .WINDOW_BITS (WIN_BITS),
    .WINDOW_WORDS(WIN_WORDS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Offset o of the bitmap stands for counter mark_q - 1 - o.
  function automatic swrc_pkg::out_item_t window_predict(swrc_pkg::in_item_t item);
    swrc_pkg::out_item_t            res;
    logic [swrc_pkg::MarkWidth-1:0] ctr;
    logic [swrc_pkg::MarkWidth-1:0] span;
    logic [swrc_pkg::MarkWidth-1:0] adv;
    logic                           ok;
    ctr = {1'b0, item.counter};
    ok  = 1'b1;
    if (item.command == swrc_pkg::CMD_CHECK) begin
      if (ctr < mark_q) begin
        span = mark_q - ctr;
        if (span > WIN_BITS) begin
          ok = 1'b0;
        end else if (seen_q[span - 1]) begin
          ok = 1'b0;
        end
        if (!ok && rejects_q != swrc_pkg::CountMax) begin
          rejects_q = rejects_q + 1'b1;
        end
      end
    end else begin
      if (ctr >= mark_q) begin
        adv    = ctr + 1 - mark_q;
        mark_q = ctr + 1;
        if (adv >= WIN_BITS) begin
          seen_q = '0;
        end else begin
          seen_q = seen_q << adv;
        end
      end
      span = mark_q - ctr;
      if (span >= 1 && span <= WIN_BITS) begin
        seen_q[span - 1] = 1'b1;
      end
    end
    res.accepted      = ok;
    res.replay_total  = rejects_q;
    res.next_expected = mark_q;
    return res;
  endfunction

  function automatic logic [swrc_pkg::CounterWidth-1:0] rand_counter();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[swrc_pkg::CounterWidth-1:0];
  endfunction

  // Offers one item, after a random gap when idle gaps are enabled, and returns at the edge of its transfer.
  task automatic send_item(swrc_pkg::cmd_e cmd, logic [swrc_pkg::CounterWidth-1:0] ctr);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid        <= 1'b1;
    in_data.command <= cmd;
    in_data.counter <= ctr;
    do @(posedge clk_i); while (!in_ready_o);
    verdict_q.push_back(window_predict(swrc_pkg::in_item_t'{command: cmd, counter: ctr}));
    items_sent++;
  endtask

  task automatic test_fresh_window();
    send_item(swrc_pkg::CMD_CHECK, '0);
    send_item(swrc_pkg::CMD_CHECK, '1);
    send_item(swrc_pkg::CMD_COMMIT, '0);
    send_item(swrc_pkg::CMD_CHECK, '0);
    send_item(swrc_pkg::CMD_CHECK, 63'd1);
  endtask

  task automatic test_window_edges();
    send_item(swrc_pkg::CMD_COMMIT, 63'd5);
    send_item(swrc_pkg::CMD_CHECK, 63'd3);
    send_item(swrc_pkg::CMD_CHECK, 63'd5);
    send_item(swrc_pkg::CMD_COMMIT, 63'd3);
    send_item(swrc_pkg::CMD_CHECK, 63'd3);
    // A large advance clears the bitmap; the oldest counter still in reach
    // sits exactly one window below the mark.
    send_item(swrc_pkg::CMD_COMMIT, 63'd2000);
    send_item(swrc_pkg::CMD_CHECK, 63'd976);
    send_item(swrc_pkg::CMD_CHECK, 63'd977);
    send_item(swrc_pkg::CMD_COMMIT, 63'd977);
    send_item(swrc_pkg::CMD_CHECK, 63'd977);
    send_item(swrc_pkg::CMD_COMMIT, 63'd10);
    send_item(swrc_pkg::CMD_CHECK, 63'd10);
    // Advance by one short of the window keeps the old bit at the far end.
    send_item(swrc_pkg::CMD_COMMIT, 63'd3000);
    send_item(swrc_pkg::CMD_COMMIT, 63'd4023);
    send_item(swrc_pkg::CMD_CHECK, 63'd3000);
    // Advance by exactly the window clears everything.
    send_item(swrc_pkg::CMD_COMMIT, 63'd5047);
    send_item(swrc_pkg::CMD_CHECK, 63'd4023);
  endtask

  // Mostly well-formed traffic placed around the current high-water mark.
  task automatic run_random(int count);
    int                             kind;
    int unsigned                    back;
    logic [swrc_pkg::MarkWidth-1:0] cand;
    swrc_pkg::cmd_e                 cmd;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
      end
      kind = $urandom_range(0, 99);
      back = $urandom_range(1, 1100);
      cmd  = swrc_pkg::CMD_CHECK;
      if (kind < 35) begin
        cmd  = swrc_pkg::CMD_COMMIT;
        cand = mark_q + $urandom_range(0, 70);
      end else if (kind < 45) begin
        cmd  = swrc_pkg::CMD_COMMIT;
        cand = mark_q + $urandom_range(0, 1500);
      end else if (kind < 60) begin
        cmd  = swrc_pkg::CMD_COMMIT;
        cand = (mark_q > back) ? mark_q - back : '0;
      end else if (kind < 90) begin
        cand = (mark_q > back) ? mark_q - back : '0;
      end else if (kind < 95) begin
        cand = mark_q + $urandom_range(0, 100);
      end else begin
        cand = {1'b0, rand_counter()};
      end
      if (cand > COUNTER_TOP) begin
        cand = COUNTER_TOP;
      end
      send_item(cmd, cand[swrc_pkg::CounterWidth-1:0]);
    end
  endtask

  task automatic test_high_counters();
    logic [swrc_pkg::CounterWidth-1:0] jump;
    jump = rand_counter();
    jump[swrc_pkg::CounterWidth-1] = 1'b0;
    send_item(swrc_pkg::CMD_COMMIT, jump);
    run_random(140);
    jump = rand_counter();
    jump[swrc_pkg::CounterWidth-1 -: 2] = 2'b10;
    send_item(swrc_pkg::CMD_COMMIT, jump);
    run_random(140);
  endtask

  task automatic test_backpressure();
    idle_on  = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_item(($urandom_range(0, 1) != 0) ? swrc_pkg::CMD_COMMIT : swrc_pkg::CMD_CHECK,
                mark_q[swrc_pkg::CounterWidth-1:0] - $urandom_range(0, 40));
    end
    idle_on = 1'b1;
  endtask

  // Runs last: once the mark passes the largest counter nothing advances it.
  task automatic test_top_of_range();
    send_item(swrc_pkg::CMD_COMMIT, COUNTER_TOP[swrc_pkg::CounterWidth-1:0]);
    send_item(swrc_pkg::CMD_CHECK, COUNTER_TOP[swrc_pkg::CounterWidth-1:0]);
    send_item(swrc_pkg::CMD_CHECK, COUNTER_TOP[swrc_pkg::CounterWidth-1:0] - 63'd1023);
    send_item(swrc_pkg::CMD_CHECK, '0);
    send_item(swrc_pkg::CMD_COMMIT, '0);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_fresh_window();
    test_window_edges();
    run_random(200);
    test_backpressure();
    test_high_counters();
    test_top_of_range();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d items, checked %0d results, %0d of them rejected as replays.",
             items_sent, results_seen, replays_seen);
    $display("Final high-water mark %0h.", mark_q);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result side: random ready gaps, plus one long hold when asked for.
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    swrc_pkg::out_item_t want;
    if (rst_n && out_valid_o && out_ready) begin
      results_seen++;
      if (out_data_o.accepted == 1'b0) begin
        replays_seen++;
      end
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: result transfer with no item outstanding: %p", $time, out_data_o);
      end else begin
        want = verdict_q.pop_front();
        if (out_data_o.accepted !== want.accepted) begin
          errors++;
          $display("%0t: accepted expected %0b, got %0b",
                   $time, want.accepted, out_data_o.accepted);
        end
        if (out_data_o.replay_total !== want.replay_total) begin
          errors++;
          $display("%0t: replay_total expected %0d, got %0d",
                   $time, want.replay_total, out_data_o.replay_total);
        end
        if (out_data_o.next_expected !== want.next_expected) begin
          errors++;
          $display("%0t: next_expected expected %0h, got %0h",
                   $time, want.next_expected, out_data_o.next_expected);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, verdict_q.size());
      $display("simulation failed");
      $finish;
    end
  end

endmodule
